>>> rtl/sti_pkg.sv
// Shared types, constants and elaboration-time table builders for the sigmoid interpolator.
`default_nettype none

package sti_pkg;

  localparam int unsigned DATA_W = 16;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned CLAMP_W = 15;

  localparam logic [CLAMP_W-1:0] CLAMP_RESET = 15'h7FFF;
  localparam logic [DATA_W-1:0] OUT_ONE = 16'hFFFF;
  localparam logic [DATA_W-1:0] OUT_ZERO = 16'h0000;

  localparam logic [63:0] Q30_ONE = 64'd1 << 30;
  localparam logic [63:0] Q30_MASK = Q30_ONE - 64'd1;
  localparam logic [63:0] Q30_EINV = 64'd395007542;

  // Control word that travels with each item from the scaler to the lookup stages.
  typedef struct packed {
    logic neg;
    logic clamped;
    logic [FRAC_W-1:0] frac;
  } lookup_t;

  // Restoring long division, used only while building the tables.
  function automatic logic [63:0] div_floor(logic [63:0] num, logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // e^-t for a non-negative Q30 argument, result in Q30.
  function automatic logic [63:0] exp_neg_q30(logic [63:0] t);
    logic [63:0] n;
    logic [63:0] u;
    logic [63:0] t1;
    logic [63:0] t2;
    logic [63:0] t3;
    logic [63:0] t4;
    logic [63:0] t5;
    logic [63:0] v;
    n = t >> 30;
    u = (t & Q30_MASK) >> 3;
    t1 = u;
    t2 = ((t1 * u) >> 30) / 2;
    t3 = ((t2 * u) >> 30) / 3;
    t4 = ((t3 * u) >> 30) / 4;
    t5 = ((t4 * u) >> 30) / 5;
    v = (Q30_ONE + t2 + t4) - (t1 + t3 + t5);
    for (int s = 0; s < 3; s++) begin
      v = (v * v) >> 30;
    end
    for (longint unsigned k = 0; k < n; k++) begin
      v = (v * Q30_EINV) >> 30;
    end
    return v;
  endfunction

  // One sigmoid sample in unsigned Q0.16 for table entry idx.
  function automatic logic [DATA_W-1:0] sample_entry(int unsigned idx, int unsigned len,
                                                      int unsigned tmax);
    logic [63:0] t;
    logic [63:0] den;
    logic [63:0] q;
    t = div_floor((64'(idx) * 64'(tmax)) << 30, 64'(len - 1));
    den = Q30_ONE + exp_neg_q30(t);
    q = div_floor((64'd1 << 46) + (den >> 1), den);
    if (q > 64'd65535) begin
      q = 64'd65535;
    end
    return q[DATA_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/sti_rom.sv
// Combined sample and slope ROM with a registered read port.
`default_nettype none

module sti_rom #(
  parameter int unsigned TABLE_LENGTH = 1024,
  parameter int unsigned TABLE_MAX = 8,
  localparam int unsigned ADDR_W = $clog2(TABLE_LENGTH)
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [ADDR_W-1:0]             addr,
  output logic      [2*sti_pkg::DATA_W-1:0]  rdata   // sample in the low half, slope above
);

  typedef logic [2*sti_pkg::DATA_W-1:0] rom_word_t;
  typedef rom_word_t rom_t [TABLE_LENGTH];

  function automatic rom_t build_rom();
    rom_t rom;
    logic [sti_pkg::DATA_W-1:0] cur;
    logic [sti_pkg::DATA_W-1:0] nxt;
    cur = sti_pkg::sample_entry(0, TABLE_LENGTH, TABLE_MAX);
    for (int unsigned i = 0; i < TABLE_LENGTH; i++) begin
      if (i + 1 < TABLE_LENGTH) begin
        nxt = sti_pkg::sample_entry(i + 1, TABLE_LENGTH, TABLE_MAX);
        rom[i] = {nxt - cur, cur};
      end else begin
        nxt = cur;
        rom[i] = {{sti_pkg::DATA_W{1'b0}}, cur};
      end
      cur = nxt;
    end
    return rom;
  endfunction

  localparam rom_t TABLE = build_rom();

  always_ff @(posedge clk) begin
    if (en) begin
      rdata <= TABLE[addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/sti_scale.sv
// Front stages: magnitude, clamp test and scaling of the sample onto the table grid.
`default_nettype none

module sti_scale #(
  parameter int unsigned TABLE_LENGTH = 1024,
  parameter int unsigned TABLE_MAX = 8,
  localparam int unsigned ADDR_W = $clog2(TABLE_LENGTH)
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [sti_pkg::DATA_W-1:0]      sample,
  input  wire logic [sti_pkg::CLAMP_W-1:0]     clamp_limit,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [ADDR_W-1:0]               out_addr,
  output sti_pkg::lookup_t                     out_ctl
);

  // floor(mag * SCALED / TABLE_MAX) = mag * DIV_A + floor(mag * DIV_B / TABLE_MAX)
  localparam int unsigned SPAN = TABLE_LENGTH - 1;
  localparam int unsigned SCALED = SPAN * 32;
  localparam int unsigned DIV_A = SCALED / TABLE_MAX;
  localparam int unsigned DIV_B = SCALED % TABLE_MAX;
  localparam int unsigned MAG_W = sti_pkg::DATA_W;
  localparam int unsigned A_W = $clog2(DIV_A + 1);
  localparam int unsigned B_W = $clog2(TABLE_MAX) + 1;
  localparam int unsigned PA_W = MAG_W + A_W;
  localparam int unsigned PB_W = MAG_W + B_W;
  localparam int unsigned SH = PB_W + 5;
  localparam int unsigned POS_W = PA_W + 1;
  localparam int unsigned K_W = POS_W - sti_pkg::FRAC_W;
  localparam logic [SH:0] RECIP = (SH+1)'(((64'd1 << SH) + 64'(TABLE_MAX) - 64'd1)
                                          / 64'(TABLE_MAX));

  logic [MAG_W-1:0] mag;
  logic             neg_in;

  logic             s1_valid;
  logic             s1_neg;
  logic             s1_clamped;
  logic [PA_W-1:0]  s1_prod_a;
  logic [PB_W-1:0]  s1_prod_b;
  logic             s1_ready;
  logic             s2_ready;

  logic [PB_W+SH:0] recip_prod;
  logic [POS_W-1:0] pos;
  logic [K_W-1:0]   k;

  assign neg_in = sample[sti_pkg::DATA_W-1];
  assign mag = neg_in ? (~sample + 1'b1) : sample;

  assign s2_ready = !out_valid || out_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_neg <= neg_in;
      s1_clamped <= mag > {1'b0, clamp_limit};
      s1_prod_a <= PA_W'(mag * A_W'(DIV_A));
      s1_prod_b <= PB_W'(mag * B_W'(DIV_B));
    end
  end

  // Exact division of the small remainder product by the table scale.
  assign recip_prod = (PB_W + SH + 1)'(s1_prod_b * RECIP);
  assign pos = POS_W'(s1_prod_a) + POS_W'(recip_prod >> SH);
  assign k = pos[POS_W-1:sti_pkg::FRAC_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      out_ctl.neg <= s1_neg;
      out_ctl.clamped <= s1_clamped;
      out_ctl.frac <= pos[sti_pkg::FRAC_W-1:0];
      if (k >= K_W'(SPAN)) begin
        out_addr <= ADDR_W'(SPAN);
      end else begin
        out_addr <= k[ADDR_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/sigmoid_table_interpolator_top.sv
// Top level of the sigmoid interpolator: scaler, table memory, interpolation and output register.
`default_nettype none

// Logistic sigmoid of a signed Q5.11 sample, answered as unsigned Q0.16 where 65535 stands
// for one. A sample whose magnitude exceeds clamp_limit gives 65535 when positive and 0 when
// negative; a sample equal to the limit is still looked up. Every other sample is scaled by
// (TABLE_LENGTH-1)/TABLE_MAX, its integer part addresses one ROM word holding the table sample
// and the slope to the next entry, and the fraction interpolates between them; past the table
// end the last sample is returned. Negative samples use the symmetry 1 - f(|x|). The block
// takes one transfer per clock cycle while the output is not stalled and returns one result
// per transfer, in order, after two scaling stages, the ROM read, the slope multiply and the
// output register. Each stage holds its item independently, so a stalled output only fills
// the pipeline behind it. The tables are fixed when the design is elaborated, so no fill pass
// follows reset. The user must write clamp_limit through cfg_wen and cfg_wdata only while
// the block holds no item; the block itself does not enforce this. It resets to 32767.

module sigmoid_table_interpolator_top #(
  parameter int unsigned TABLE_LENGTH = 1024,
  parameter int unsigned TABLE_MAX = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [sti_pkg::DATA_W-1:0]      s_axis_tdata,   // [15:0] sample_in
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic      [sti_pkg::DATA_W-1:0]      m_axis_tdata,   // [15:0] sigmoid_out
  input  wire logic                            cfg_wen,
  input  wire logic [sti_pkg::CLAMP_W-1:0]     cfg_wdata       // clamp_limit
);

  localparam int unsigned ADDR_W = $clog2(TABLE_LENGTH);
  localparam int unsigned DW = sti_pkg::DATA_W;

  logic [sti_pkg::CLAMP_W-1:0] clamp_limit;

  // Scaler to memory stage.
  logic                lk_valid;
  logic [ADDR_W-1:0]   lk_addr;
  sti_pkg::lookup_t    lk_ctl;

  // Memory stage: the ROM word arrives with its control word.
  logic                r_valid;
  logic                r_ready;
  sti_pkg::lookup_t    r_ctl;
  logic [2*DW-1:0]     rom_data;

  // Multiply stage.
  logic                m_valid;
  logic                m_ready;
  logic                m_neg;
  logic                m_clamped;
  logic [DW-1:0]       m_sample;
  logic [2*DW-1:0]     m_prod;

  // Output stage.
  logic                o_ready;
  logic [2*DW:0]       rounded;
  logic [DW:0]         y;
  logic [DW-1:0]       result;

  always_ff @(posedge clk) begin
    if (rst) begin
      clamp_limit <= sti_pkg::CLAMP_RESET;
    end else if (cfg_wen) begin
      clamp_limit <= cfg_wdata;
    end
  end

  sti_scale #(
    .TABLE_LENGTH (TABLE_LENGTH),
    .TABLE_MAX    (TABLE_MAX)
  ) u_scale (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .sample      (s_axis_tdata),
    .clamp_limit (clamp_limit),
    .out_valid   (lk_valid),
    .out_ready   (r_ready),
    .out_addr    (lk_addr),
    .out_ctl     (lk_ctl)
  );

  // Each stage moves on when it is empty or the stage after it moves on.
  assign o_ready = !m_axis_tvalid || m_axis_tready;
  assign m_ready = !m_valid || o_ready;
  assign r_ready = !r_valid || m_ready;

  sti_rom #(
    .TABLE_LENGTH (TABLE_LENGTH),
    .TABLE_MAX    (TABLE_MAX)
  ) u_rom (
    .clk   (clk),
    .en    (lk_valid && r_ready),
    .addr  (lk_addr),
    .rdata (rom_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (r_ready) begin
      r_valid <= lk_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (r_ready && lk_valid) begin
      r_ctl <= lk_ctl;
    end
  end

  // The slope of the last entry is zero, so an address pinned at the table end
  // returns the last sample whatever the fraction.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (m_ready) begin
      m_valid <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (m_ready && r_valid) begin
      m_neg <= r_ctl.neg;
      m_clamped <= r_ctl.clamped;
      m_sample <= rom_data[DW-1:0];
      m_prod <= rom_data[2*DW-1:DW] * r_ctl.frac;
    end
  end

  // Rounded interpolation, then the symmetry for negative samples and saturation to one.
  assign rounded = {1'b0, m_prod} + (2*DW+1)'(33'd32768);
  assign y = {1'b0, m_sample} + (DW+1)'(rounded[2*DW:DW]);

  always_comb begin
    if (m_clamped) begin
      result = m_neg ? sti_pkg::OUT_ZERO : sti_pkg::OUT_ONE;
    end else if (m_neg) begin
      if (y == '0 || y > 17'd65536) begin
        result = sti_pkg::OUT_ONE;
      end else begin
        result = DW'(17'd65536 - y);
      end
    end else if (y[DW]) begin
      result = sti_pkg::OUT_ONE;
    end else begin
      result = y[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (o_ready) begin
      m_axis_tvalid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_ready && m_valid) begin
      m_axis_tdata <= result;
    end
  end

endmodule

`default_nettype wire
